// ===== hw/rtl/bdsp_pkg.sv =====
package bdsp_pkg;

	localparam int INTERLEAVE_BYTES = 288;
	localparam int MAX_STREAMS = 8;
	localparam int SEARCH_LIMIT = 100;

	localparam int HDR_LEN = 13;
	localparam int NAME_LO = 8'h61;
	localparam int NAME_HI = 8'h65;
	localparam int LONG_CLAMP = 300 * 1024;
	localparam int SHORT_CLAMP = 64;

	localparam int CHUNK_W = (INTERLEAVE_BYTES > 1) ? $clog2(INTERLEAVE_BYTES) : 1;
	localparam int LANE_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int CNT_W = 5;
	// worst case: name byte at the limit minus one, then four length bytes
	localparam int SC_W = $clog2(SEARCH_LIMIT + 5);
	localparam int HIDX_W = 4;
	localparam int LEN_W = 19;
	localparam int ACC_W = 32;
	localparam int LEFT_W = 3;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;
	localparam int COUNT_W = 4;
	localparam int SELECT_W = 3;
	localparam int NAME_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STREAM_COUNT   = 2'd0,
		CFG_STREAM_SELECT  = 2'd1,
		CFG_WANTED_SECTION = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_FOUND     = 2'd1,
		KIND_MISMATCH  = 2'd2,
		KIND_NOT_FOUND = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NAME,
		PH_LENGTH,
		PH_SKIP,
		PH_PAYLOAD,
		PH_IDLE
	} phase_t;

	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             last;
	} res_t;

	function automatic logic [7:0] hdr_byte(input logic [HIDX_W-1:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0:  v = 8'h00;
			4'd1:  v = 8'h09;
			4'd2:  v = 8'h0f;
			4'd3:  v = 8'hf0;
			4'd4:  v = 8'h0f;
			4'd5:  v = 8'hf0;
			4'd6:  v = 8'h0f;
			4'd7:  v = 8'hf0;
			4'd8:  v = 8'h0f;
			4'd9:  v = 8'hf0;
			4'd10: v = 8'h00;
			4'd11: v = 8'h00;
			4'd12: v = 8'h01;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/bitstream_deinterleave_section_parser.sv =====
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    in_byte, first
// out       out  out_valid / out_stall  kind, out_byte, found_len, last
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while out_stall does not hold a full output register; an item's result (if any)
// is held in the input register, then passes through the parser into the output register.
// arst_n clears lane counters, parser state and registers to their defaults.
// out_stall holds the output register and, once the input register is full, raises in_stall.
// cfg_ready is always high; registers are meant to be written while no item is in flight.
module bitstream_deinterleave_section_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      in_byte,
	input  logic                            first,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bdsp_pkg::kind_t                 kind,
	output logic [7:0]                      out_byte,
	output logic [bdsp_pkg::LEN_W-1:0]      found_len,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bdsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bdsp_pkg::*;

	logic [COUNT_W-1:0]  stream_count_q;
	logic [SELECT_W-1:0] stream_select_q;
	logic [NAME_W-1:0]   wanted_q;

	logic       valid_s1, first_s1;
	logic [7:0] byte_s1;
	logic       adv, fire, accept, sel;
	res_t       res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_count_q <= COUNT_W'(2);
			stream_select_q <= '0;
			wanted_q <= NAME_W'(NAME_HI);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STREAM_COUNT:   stream_count_q <= cfg_data[COUNT_W-1:0];
				CFG_STREAM_SELECT:  stream_select_q <= cfg_data[SELECT_W-1:0];
				CFG_WANTED_SECTION: wanted_q <= cfg_data[NAME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv = !out_valid || !out_stall;
	assign fire = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			first_s1 <= first;
		end
	end

	bdsp_lane u_lane (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.first         (first_s1),
		.stream_count  (stream_count_q),
		.stream_select (stream_select_q),
		.sel           (sel)
	);

	bdsp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.sel            (sel),
		.first          (first_s1),
		.data           (byte_s1),
		.wanted_section (wanted_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire && res.valid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			kind <= res.kind;
			out_byte <= res.data;
			found_len <= res.len;
			last <= res.last;
		end
	end

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled without a held item");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.valid |=> out_valid)
		else $error("parser result not registered");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == KIND_PAYLOAD || kind == KIND_FOUND)
		else $error("last flag on a status item");

	a_byte_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> out_byte == 8'h00)
		else $error("data byte on a status item");

endmodule

// ===== hw/rtl/bdsp_lane.sv =====
module bdsp_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         first,
	input  logic [bdsp_pkg::COUNT_W-1:0]  stream_count,
	input  logic [bdsp_pkg::SELECT_W-1:0] stream_select,
	output logic                         sel
);
	import bdsp_pkg::*;

	logic [CHUNK_W-1:0] chunk_pos_q, chunk_cur, chunk_nxt;
	logic [LANE_W-1:0]  lane_q, lane_cur, lane_nxt;
	logic [CNT_W-1:0]   cnt_ext, cnt_eff, lane_inc;

	always_comb begin
		cnt_ext = CNT_W'(stream_count);
		if (cnt_ext == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (cnt_ext > CNT_W'(MAX_STREAMS)) begin
			cnt_eff = CNT_W'(MAX_STREAMS);
		end else begin
			cnt_eff = cnt_ext;
		end
	end

	always_comb begin
		chunk_cur = first ? '0 : chunk_pos_q;
		lane_cur = first ? '0 : lane_q;
		sel = (CNT_W'(stream_select) < cnt_eff) && (CNT_W'(lane_cur) == CNT_W'(stream_select));
		lane_inc = CNT_W'(lane_cur) + CNT_W'(1);
		chunk_nxt = chunk_cur + CHUNK_W'(1);
		lane_nxt = lane_cur;
		if ((CNT_W + CHUNK_W)'(chunk_cur) + (CNT_W + CHUNK_W)'(1)
				>= (CNT_W + CHUNK_W)'(INTERLEAVE_BYTES)) begin
			chunk_nxt = '0;
			// a lane left beyond a shrunk count wraps here as well
			lane_nxt = (lane_inc >= cnt_eff) ? '0 : LANE_W'(lane_inc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_pos_q <= '0;
			lane_q <= '0;
		end else if (fire) begin
			chunk_pos_q <= chunk_nxt;
			lane_q <= lane_nxt;
		end
	end

endmodule

// ===== hw/rtl/bdsp_parser.sv =====
module bdsp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        sel,
	input  logic                        first,
	input  logic [7:0]                  data,
	input  logic [bdsp_pkg::NAME_W-1:0] wanted_section,
	output bdsp_pkg::res_t              res
);
	import bdsp_pkg::*;

	phase_t            phase_q, ph_c, ph_n;
	logic [HIDX_W-1:0] hidx_q, hidx_c, hidx_n;
	logic              match_q, match_c, match_n;
	logic [SC_W-1:0]   sc_q, sc_c, sc_n;
	logic [NAME_W-1:0] name_q, name_c, name_n;
	logic [ACC_W-1:0]  acc_q, acc_c, acc_n;
	logic [LEFT_W-1:0] left_q, left_c, left_n;
	logic [LEN_W-1:0]  rem_q, rem_c, rem_n;
	logic [LEN_W-1:0]  clamped;
	logic              is_long;

	// first restarts the parser before the item is looked at
	always_comb begin
		ph_c = first ? PH_HEADER : phase_q;
		hidx_c = first ? '0 : hidx_q;
		match_c = first ? 1'b1 : match_q;
		sc_c = first ? '0 : sc_q;
		name_c = first ? '0 : name_q;
		acc_c = first ? '0 : acc_q;
		left_c = first ? '0 : left_q;
		rem_c = first ? '0 : rem_q;
	end

	always_comb begin
		ph_n = ph_c;
		hidx_n = hidx_c;
		match_n = match_c;
		sc_n = sc_c;
		name_n = name_c;
		acc_n = acc_c;
		left_n = left_c;
		rem_n = rem_c;
		res = '0;
		res.kind = KIND_PAYLOAD;
		is_long = (name_c == NAME_W'(NAME_HI));
		clamped = '0;
		if (sel) begin
			case (ph_c)
				PH_HEADER: begin
					if (hidx_c < HIDX_W'(HDR_LEN) && hdr_byte(hidx_c) != data) begin
						match_n = 1'b0;
					end
					hidx_n = hidx_c + HIDX_W'(1);
					if (hidx_n >= HIDX_W'(HDR_LEN)) begin
						if (match_n) begin
							ph_n = PH_NAME;
						end else begin
							ph_n = PH_IDLE;
							res.valid = 1'b1;
							res.kind = KIND_MISMATCH;
						end
					end
				end
				PH_NAME: begin
					sc_n = sc_c + SC_W'(1);
					if (data < 8'(NAME_LO) || data > 8'(NAME_HI)) begin
						ph_n = PH_IDLE;
						res.valid = 1'b1;
						res.kind = KIND_NOT_FOUND;
					end else begin
						name_n = data[NAME_W-1:0];
						acc_n = '0;
						left_n = (data == 8'(NAME_HI)) ? LEFT_W'(4) : LEFT_W'(2);
						ph_n = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					acc_n = {acc_c[ACC_W-9:0], data};
					sc_n = sc_c + SC_W'(1);
					if (left_c != '0) begin
						left_n = left_c - LEFT_W'(1);
					end
					if (is_long) begin
						clamped = (acc_n > ACC_W'(LONG_CLAMP)) ? LEN_W'(LONG_CLAMP)
							: acc_n[LEN_W-1:0];
					end else begin
						clamped = (acc_n > ACC_W'(SHORT_CLAMP)) ? LEN_W'(SHORT_CLAMP)
							: acc_n[LEN_W-1:0];
					end
					if (left_n == '0) begin
						if (name_c == wanted_section) begin
							rem_n = clamped;
							ph_n = (clamped != '0) ? PH_PAYLOAD : PH_IDLE;
							res.valid = 1'b1;
							res.kind = KIND_FOUND;
							res.len = clamped;
							res.last = (clamped == '0);
						end else if (sc_n >= SC_W'(SEARCH_LIMIT)) begin
							ph_n = PH_IDLE;
							res.valid = 1'b1;
							res.kind = KIND_NOT_FOUND;
						end else begin
							rem_n = clamped;
							ph_n = (clamped != '0) ? PH_SKIP : PH_NAME;
						end
					end
				end
				PH_SKIP: begin
					sc_n = sc_c + SC_W'(1);
					if (rem_c != '0) begin
						rem_n = rem_c - LEN_W'(1);
					end
					if (sc_n >= SC_W'(SEARCH_LIMIT)) begin
						ph_n = PH_IDLE;
						res.valid = 1'b1;
						res.kind = KIND_NOT_FOUND;
					end else if (rem_n == '0) begin
						ph_n = PH_NAME;
					end
				end
				PH_PAYLOAD: begin
					if (rem_c != '0) begin
						rem_n = rem_c - LEN_W'(1);
					end
					if (rem_n == '0) begin
						ph_n = PH_IDLE;
					end
					res.valid = 1'b1;
					res.kind = KIND_PAYLOAD;
					res.data = data;
					res.last = (rem_n == '0);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q <= '0;
			match_q <= 1'b1;
			sc_q <= '0;
			name_q <= '0;
			acc_q <= '0;
			left_q <= '0;
			rem_q <= '0;
		end else if (fire) begin
			phase_q <= ph_n;
			hidx_q <= hidx_n;
			match_q <= match_n;
			sc_q <= sc_n;
			name_q <= name_n;
			acc_q <= acc_n;
			left_q <= left_n;
			rem_q <= rem_n;
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import bdsp_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam logic [103:0] HEADER_SEQ = 104'h00_09_0f_f0_0f_f0_0f_f0_0f_f0_00_00_01;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} stream_item_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             last;
	} section_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_byte = 8'h00;
	logic                  first = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	kind_t                 kind;
	logic [7:0]            out_byte;
	logic [LEN_W-1:0]      found_len;
	logic                  last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bitstream_deinterleave_section_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.first(first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.found_len(found_len),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [COUNT_W-1:0]  p_count;
	logic [SELECT_W-1:0] p_select;
	logic [NAME_W-1:0]   p_wanted;
	int unsigned         p_pos;
	int unsigned         p_lane;
	phase_t              p_phase;
	int unsigned         p_hidx;
	bit                  p_hmatch;
	int unsigned         p_searched;
	logic [7:0]          p_name;
	logic [31:0]         p_accum;
	int unsigned         p_len_left;
	logic [LEN_W-1:0]    p_remain;

	stream_item_t    pending_items[$];
	section_report_t expected_reports[$];
	logic [7:0]      image_bytes[$];

	stream_item_t    next_item;
	section_report_t oldest;
	bit              in_fire = 1'b0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              fail_count = 0;
	int unsigned     cycle_count = 0;

	function automatic void restart_parser();
		p_pos = 0;
		p_lane = 0;
		p_phase = PH_HEADER;
		p_hidx = 0;
		p_hmatch = 1'b1;
		p_searched = 0;
		p_name = '0;
		p_accum = '0;
		p_len_left = 0;
		p_remain = '0;
	endfunction

	function automatic int unsigned lanes_in_use();
		if (p_count == 0)
			return 1;
		if (p_count > MAX_STREAMS)
			return MAX_STREAMS;
		return p_count;
	endfunction

	function automatic void expect_report(kind_t k, logic [7:0] d, logic [LEN_W-1:0] l,
			logic lst);
		section_report_t r;
		r.kind = k;
		r.data = d;
		r.len = l;
		r.last = lst;
		expected_reports.push_back(r);
	endfunction

	function automatic void parse_lane_byte(logic [7:0] b);
		logic [31:0] clamped;
		case (p_phase)
			PH_HEADER: begin
				if (HEADER_SEQ[103 - 8 * p_hidx -: 8] != b)
					p_hmatch = 1'b0;
				p_hidx++;
				if (p_hidx >= HDR_LEN) begin
					if (p_hmatch) begin
						p_phase = PH_NAME;
					end else begin
						p_phase = PH_IDLE;
						expect_report(KIND_MISMATCH, '0, '0, 1'b0);
					end
				end
			end
			PH_NAME: begin
				p_searched++;
				if (b < NAME_LO || b > NAME_HI) begin
					p_phase = PH_IDLE;
					expect_report(KIND_NOT_FOUND, '0, '0, 1'b0);
				end else begin
					p_name = b;
					p_accum = '0;
					p_len_left = (b == NAME_HI) ? 4 : 2;
					p_phase = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				p_accum = {p_accum[23:0], b};
				p_searched++;
				if (p_len_left > 0)
					p_len_left--;
				if (p_len_left == 0) begin
					clamped = p_accum;
					if (p_name == NAME_HI) begin
						if (clamped > LONG_CLAMP)
							clamped = LONG_CLAMP;
					end else if (clamped > SHORT_CLAMP) begin
						clamped = SHORT_CLAMP;
					end
					if (p_name == {1'b0, p_wanted}) begin
						p_remain = clamped[LEN_W-1:0];
						p_phase = (clamped > 0) ? PH_PAYLOAD : PH_IDLE;
						expect_report(KIND_FOUND, '0, clamped[LEN_W-1:0], clamped == 0);
					end else if (p_searched >= SEARCH_LIMIT) begin
						p_phase = PH_IDLE;
						expect_report(KIND_NOT_FOUND, '0, '0, 1'b0);
					end else begin
						p_remain = clamped[LEN_W-1:0];
						p_phase = (clamped > 0) ? PH_SKIP : PH_NAME;
					end
				end
			end
			PH_SKIP: begin
				p_searched++;
				if (p_remain > 0)
					p_remain--;
				if (p_searched >= SEARCH_LIMIT) begin
					p_phase = PH_IDLE;
					expect_report(KIND_NOT_FOUND, '0, '0, 1'b0);
				end else if (p_remain == 0) begin
					p_phase = PH_NAME;
				end
			end
			PH_PAYLOAD: begin
				if (p_remain > 0)
					p_remain--;
				if (p_remain == 0)
					p_phase = PH_IDLE;
				expect_report(KIND_PAYLOAD, b, '0, p_remain == 0);
			end
			default: ;
		endcase
	endfunction

	function automatic void track_stream_byte(logic [7:0] b, logic start);
		int unsigned cnt;
		if (start)
			restart_parser();
		cnt = lanes_in_use();
		if (p_select < cnt && p_lane == p_select)
			parse_lane_byte(b);
		p_pos++;
		if (p_pos >= INTERLEAVE_BYTES) begin
			p_pos = 0;
			p_lane++;
			if (p_lane >= cnt)
				p_lane = 0;
		end
	endfunction

	function automatic void push_raw(logic [7:0] b, logic start);
		stream_item_t it;
		it.data = b;
		it.start = start;
		pending_items.push_back(it);
	endfunction

	function automatic void add_header();
		for (int i = 0; i < HDR_LEN; i++)
			image_bytes.push_back(HEADER_SEQ[103 - 8 * i -: 8]);
	endfunction

	function automatic void add_section(logic [7:0] name, logic [31:0] raw_len,
			int unsigned body_cap);
		int unsigned body;
		image_bytes.push_back(name);
		if (name == NAME_HI) begin
			for (int s = 24; s >= 0; s -= 8)
				image_bytes.push_back(raw_len[s +: 8]);
			body = raw_len;
		end else begin
			image_bytes.push_back(raw_len[15:8]);
			image_bytes.push_back(raw_len[7:0]);
			body = (raw_len[15:0] > SHORT_CLAMP) ? SHORT_CLAMP : raw_len[15:0];
		end
		if (body > body_cap)
			body = body_cap;
		repeat (body) image_bytes.push_back(8'($urandom_range(255)));
	endfunction

	function automatic logic [7:0] other_name();
		logic [7:0] nm;
		do
			nm = 8'($urandom_range(NAME_HI, NAME_LO));
		while (nm == {1'b0, p_wanted});
		return nm;
	endfunction

	function automatic logic [7:0] bad_name();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'(NAME_LO - 1);
			2: return 8'(NAME_HI + 1);
			default: return 8'($urandom_range(255, NAME_HI + 1));
		endcase
	endfunction

	// one image of the selected lane: header, sections to skip, then the target or a bad name byte
	function automatic void make_image();
		int unsigned style;
		int unsigned n;
		logic [31:0] raw;
		image_bytes.delete();
		add_header();
		if ($urandom_range(11) == 0)
			image_bytes[$urandom_range(HDR_LEN - 1)] = 8'($urandom_range(255));
		style = $urandom_range(9);
		if (style == 0) begin
			// empty sections only, so the budget runs out on a length byte
			n = $urandom_range(45, 34);
			repeat (n) add_section(other_name(), 0, 0);
		end else begin
			n = $urandom_range(3);
			repeat (n) begin
				raw = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(30);
				add_section(other_name(), raw, SHORT_CLAMP);
			end
		end
		if (style == 1) begin
			image_bytes.push_back(bad_name());
		end else begin
			case (style)
				2: raw = $urandom();
				3: raw = 0;
				4: raw = $urandom_range(400, 290);
				default: raw = $urandom_range(24, 1);
			endcase
			add_section({1'b0, p_wanted}, raw, (style == 4) ? 400 : 80);
		end
		repeat ($urandom_range(4)) image_bytes.push_back(8'($urandom_range(255)));
	endfunction

	// spread the image over its lane, other lanes get filler; returns lane bytes queued (0 if select is past the count)
	function automatic int unsigned queue_image();
		int unsigned cnt;
		int unsigned pos;
		int unsigned ln;
		int unsigned idx;
		logic st;
		cnt = lanes_in_use();
		if (p_select >= cnt) begin
			foreach (image_bytes[i])
				push_raw(image_bytes[i], i == 0);
			return 0;
		end
		pos = 0;
		ln = 0;
		idx = 0;
		st = 1'b1;
		while (idx < image_bytes.size()) begin
			if (ln == p_select) begin
				push_raw(image_bytes[idx], st);
				idx++;
			end else begin
				push_raw(8'($urandom_range(255)), st);
			end
			st = 1'b0;
			pos++;
			if (pos == INTERLEAVE_BYTES) begin
				pos = 0;
				ln = (ln + 1) % cnt;
			end
		end
		return image_bytes.size();
	endfunction

	function automatic void compare_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
			fail_count++;
		end
	endfunction

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		wait_quiet();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_STREAM_COUNT:   p_count = val[COUNT_W-1:0];
			CFG_STREAM_SELECT:  p_select = val[SELECT_W-1:0];
			CFG_WANTED_SECTION: p_wanted = val[NAME_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_setting(logic [CFG_DATA_W-1:0] cnt, logic [CFG_DATA_W-1:0] sel,
			logic [CFG_DATA_W-1:0] want, int unsigned target);
		int unsigned done;
		int unsigned n;
		write_reg(CFG_STREAM_COUNT, cnt);
		write_reg(CFG_STREAM_SELECT, sel);
		write_reg(CFG_WANTED_SECTION, want);
		done = 0;
		while (done < target) begin
			if ($urandom_range(14) == 0) begin
				// raw noise with stray restarts
				n = $urandom_range(40, 5);
				for (int k = 0; k < n; k++)
					push_raw(8'($urandom_range(255)),
						(k == 0) ? 1'($urandom_range(1)) : ($urandom_range(31) == 0));
			end else begin
				make_image();
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(image_bytes.size() - 1))
						void'(image_bytes.pop_back());
				done += queue_image();
			end
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (arst_n && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				in_byte <= next_item.data;
				first <= next_item.start;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire)
			track_stream_byte(in_byte, first);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected item, kind %0d byte %0d length %0d last %0b",
					$time, kind, out_byte, found_len, last);
				fail_count++;
			end else begin
				oldest = expected_reports.pop_front();
				compare_field("kind", oldest.kind, kind);
				compare_field("out_byte", oldest.data, out_byte);
				compare_field("found_len", oldest.len, found_len);
				compare_field("last", oldest.last, last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout", $time);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		p_count = COUNT_W'(2);
		p_select = '0;
		p_wanted = NAME_W'(NAME_HI);
		restart_parser();
		send_idle_pct = 34;
		recv_idle_pct = 73;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// oversized long length gets clamped; payload cut short by the next restart
		image_bytes.delete();
		add_header();
		add_section(8'(NAME_HI), 32'h0005_0000, 3);
		void'(queue_image());
		// header mismatch on its last byte, then bytes that must be ignored
		image_bytes.delete();
		add_header();
		image_bytes[HDR_LEN - 1] = 8'hff;
		image_bytes.push_back(8'(NAME_HI));
		image_bytes.push_back(8'h00);
		void'(queue_image());
		// name byte just past the legal range
		image_bytes.delete();
		add_header();
		image_bytes.push_back(8'(NAME_HI + 1));
		void'(queue_image());
		// clamped short section skipped, then an empty wanted section
		image_bytes.delete();
		add_header();
		add_section(8'(NAME_LO), 32'h0000_ffff, SHORT_CLAMP);
		add_section(8'(NAME_HI), 0, 0);
		void'(queue_image());

		// select at or above the count: everything dropped
		write_reg(CFG_STREAM_SELECT, CFG_DATA_W'(5));
		image_bytes.delete();
		add_header();
		add_section(8'(NAME_HI), 2, 2);
		void'(queue_image());

		// header and a skipped section on lane 1, then shrink the count below the lane;
		// the rest of the chunk is dropped and the search goes on in lane 0
		write_reg(CFG_STREAM_COUNT, CFG_DATA_W'(15));
		write_reg(CFG_STREAM_SELECT, CFG_DATA_W'(1));
		write_reg(CFG_WANTED_SECTION, CFG_DATA_W'(NAME_LO + 2));
		image_bytes.delete();
		add_header();
		add_section(8'(NAME_LO), 2, 2);
		for (int k = 0; k < INTERLEAVE_BYTES; k++)
			push_raw(8'($urandom_range(255)), k == 0);
		foreach (image_bytes[i])
			push_raw(image_bytes[i], 1'b0);
		write_reg(CFG_STREAM_COUNT, CFG_DATA_W'(1));
		write_reg(CFG_STREAM_SELECT, CFG_DATA_W'(0));
		repeat (INTERLEAVE_BYTES - image_bytes.size())
			push_raw(8'($urandom_range(255)), 1'b0);
		image_bytes.delete();
		add_section(8'(NAME_LO + 2), 3, 3);
		foreach (image_bytes[i])
			push_raw(image_bytes[i], 1'b0);

		wait_quiet();
		send_idle_pct = 73;
		recv_idle_pct = 34;
		run_setting(CFG_DATA_W'(0), CFG_DATA_W'(0), CFG_DATA_W'(NAME_LO + 1), 60);

		wait_quiet();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_setting(CFG_DATA_W'(1), CFG_DATA_W'(0), CFG_DATA_W'(NAME_HI), 60);

		wait_quiet();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
